### sv/bgu_pkg.sv
package bgu_pkg;

    // fixed field widths
    localparam int GRID_CFG_W = 5;
    localparam int STEP_W     = 20;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int SAMPLE_W   = 8;
    localparam int STORE_AW   = 8;
    localparam int STORE_DEPTH = 1 << STORE_AW;
    localparam int NUM_TAPS   = 4;

    // parameter defaults
    localparam int MAX_GRID_SIDE_DEF = 16;
    localparam int FRAC_BITS_DEF     = 16;
    localparam int COORD_BITS_DEF    = 12;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y      = 2'd3;

    localparam logic [GRID_CFG_W-1:0] GRID_WIDTH_RST  = 5'd4;
    localparam logic [GRID_CFG_W-1:0] GRID_HEIGHT_RST = 5'd4;
    localparam logic [STEP_W-1:0]     STEP_X_RST      = 20'd614;
    localparam logic [STEP_W-1:0]     STEP_Y_RST      = 20'd614;

    // item function codes
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_INTERP = 1'b1;

    // tap order: top-left, top-right, bottom-left, bottom-right
    localparam int TAP_A = 0;
    localparam int TAP_B = 1;
    localparam int TAP_C = 2;
    localparam int TAP_D = 3;

    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic [SAMPLE_W-1:0] data;
    } t_grid_wr;

    typedef struct packed {
        logic                              en;
        logic [NUM_TAPS-1:0][STORE_AW-1:0] addr;
    } t_grid_rd;

endpackage

### sv/bilinear_grid_upscaler_top.sv
// Channel   Dir  Handshake                  Payload
// -------   ---  -------------------------  ------------------------------------------
// in        in   i_in_valid / o_in_ready    i_func, i_grid_index, i_grid_value,
//                                           i_out_x, i_out_y
// out       out  o_out_valid / i_out_ready  o_pixel, o_pixel_x, o_pixel_y
// cfg       in   i_cfg_we (no ready)        i_cfg_index, i_cfg_data
//
// One beat enters per clock while o_in_ready is high. An interpolate beat passes through
// eight register stages (three multiplier stages, index/address stages, grid read, two
// adders) on its way to the output. Load beats write the grid when they pass stage 3
// and leave nothing. Reset clears valid bits and configuration; the grid itself is not
// cleared. Each stage advances while empty or while the stage after it advances, so
// bubbles collapse and a stalled output still lets earlier stages fill.
module bilinear_grid_upscaler_top #(
    parameter int MAX_GRID_SIDE = bgu_pkg::MAX_GRID_SIDE_DEF,
    parameter int FRAC_BITS     = bgu_pkg::FRAC_BITS_DEF,
    parameter int COORD_BITS    = bgu_pkg::COORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input beats
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_func,
    input  logic [bgu_pkg::STORE_AW-1:0]     i_grid_index,
    input  logic [bgu_pkg::SAMPLE_W-1:0]     i_grid_value,
    input  logic [COORD_BITS-1:0]            i_out_x,
    input  logic [COORD_BITS-1:0]            i_out_y,
    // result beats
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [bgu_pkg::SAMPLE_W-1:0]     o_pixel,
    output logic [COORD_BITS-1:0]            o_pixel_x,
    output logic [COORD_BITS-1:0]            o_pixel_y,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [bgu_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bgu_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bgu_pkg::*;

    // side lengths up to MAX_GRID_SIDE, indices below it
    localparam int SIDE_W   = $clog2(MAX_GRID_SIDE + 1);
    localparam int PROD_W   = COORD_BITS + STEP_W;        // Q.FRAC source position
    localparam int INT_W    = PROD_W - FRAC_BITS;
    localparam int CMP_W    = (INT_W > SIDE_W) ? INT_W : SIDE_W;
    localparam int ADDR_W   = 2 * SIDE_W + 1;
    localparam int TOP_W    = SAMPLE_W + FRAC_BITS;       // Q8.FRAC row blend
    localparam int HP_W     = SAMPLE_W + FRAC_BITS + 2;   // (b-a)*fx, signed
    localparam int HS_W     = HP_W + 1;
    localparam int VP_W     = TOP_W + FRAC_BITS + 2;      // (bot-top)*fy, signed
    localparam int VS_W     = VP_W + 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [GRID_CFG_W-1:0] r_grid_width;
    logic [GRID_CFG_W-1:0] r_grid_height;
    logic [STEP_W-1:0]     r_step_x;
    logic [STEP_W-1:0]     r_step_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_WIDTH_RST;
            r_grid_height <= GRID_HEIGHT_RST;
            r_step_x      <= STEP_X_RST;
            r_step_y      <= STEP_Y_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[GRID_CFG_W-1:0];
                REG_GRID_HEIGHT: r_grid_height <= i_cfg_data[GRID_CFG_W-1:0];
                REG_STEP_X:      r_step_x      <= i_cfg_data[STEP_W-1:0];
                REG_STEP_Y:      r_step_y      <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp a side length into [1, MAX_GRID_SIDE]
    function automatic logic [SIDE_W-1:0] side_limit(input logic [GRID_CFG_W-1:0] v);
        logic [SIDE_W-1:0] r;
        if (v == '0) begin
            r = SIDE_W'(1);
        end else if (32'(v) > 32'(MAX_GRID_SIDE)) begin
            r = SIDE_W'(MAX_GRID_SIDE);
        end else begin
            r = SIDE_W'(v);
        end
        return r;
    endfunction

    // integer part saturated to last index
    function automatic logic [SIDE_W-1:0] sat_index(input logic [INT_W-1:0] v,
                                                    input logic [SIDE_W-1:0] last);
        logic [SIDE_W-1:0] r;
        if (CMP_W'(v) > CMP_W'(last)) begin
            r = last;
        end else begin
            r = SIDE_W'(v);
        end
        return r;
    endfunction

    // linear store address, wraps at the store depth
    function automatic logic [STORE_AW-1:0] addr_of(input logic [SIDE_W-1:0] row,
                                                    input logic [SIDE_W-1:0] col,
                                                    input logic [SIDE_W-1:0] w);
        logic [ADDR_W-1:0] full;
        full = ADDR_W'(row) * ADDR_W'(w) + ADDR_W'(col);
        return STORE_AW'(full);
    endfunction

    logic [SIDE_W-1:0] w_lim, h_lim, w_last, h_last;
    assign w_lim  = side_limit(r_grid_width);
    assign h_lim  = side_limit(r_grid_height);
    assign w_last = w_lim - SIDE_W'(1);
    assign h_last = h_lim - SIDE_W'(1);

    // ------------------------------------------------------------------
    // stage advance chain
    // ------------------------------------------------------------------
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic r_s5_valid, r_s6_valid, r_s7_valid, r_s8_valid;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy8;

    assign rdy8 = !r_s8_valid || i_out_ready;
    assign rdy7 = !r_s7_valid || rdy8;
    assign rdy6 = !r_s6_valid || rdy7;
    assign rdy5 = !r_s5_valid || rdy6;
    assign rdy4 = !r_s4_valid || rdy5;
    assign rdy3 = !r_s3_valid || rdy4;
    assign rdy2 = !r_s2_valid || rdy3;
    assign rdy1 = !r_s1_valid || rdy2;

    assign o_in_ready = rdy1;

    logic r_s1_func, r_s2_func, r_s3_func;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
            r_s7_valid <= 1'b0;
            r_s8_valid <= 1'b0;
        end else begin
            if (rdy1) r_s1_valid <= i_in_valid;
            if (rdy2) r_s2_valid <= r_s1_valid;
            if (rdy3) r_s3_valid <= r_s2_valid;
            // loads retire at the grid write
            if (rdy4) r_s4_valid <= r_s3_valid && (r_s3_func == FUNC_INTERP);
            if (rdy5) r_s5_valid <= r_s4_valid;
            if (rdy6) r_s6_valid <= r_s5_valid;
            if (rdy7) r_s7_valid <= r_s6_valid;
            if (rdy8) r_s8_valid <= r_s7_valid;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: scale coordinates
    // ------------------------------------------------------------------
    logic [STORE_AW-1:0]   r_s1_gidx, r_s2_gidx, r_s3_gidx;
    logic [SAMPLE_W-1:0]   r_s1_gval, r_s2_gval, r_s3_gval;
    logic [COORD_BITS-1:0] r_s1_ox, r_s2_ox, r_s3_ox, r_s4_ox, r_s5_ox, r_s6_ox, r_s7_ox;
    logic [COORD_BITS-1:0] r_s1_oy, r_s2_oy, r_s3_oy, r_s4_oy, r_s5_oy, r_s6_oy, r_s7_oy;
    logic [PROD_W-1:0]     r_s1_sx, r_s1_sy;

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_func <= i_func;
            r_s1_gidx <= i_grid_index;
            r_s1_gval <= i_grid_value;
            r_s1_ox   <= i_out_x;
            r_s1_oy   <= i_out_y;
            r_s1_sx   <= PROD_W'(i_out_x) * PROD_W'(r_step_x);
            r_s1_sy   <= PROD_W'(i_out_y) * PROD_W'(r_step_y);
        end
    end

    // ------------------------------------------------------------------
    // stage 2: neighbor indices and fractions
    // ------------------------------------------------------------------
    logic [SIDE_W-1:0]    rx, ry;
    logic [SIDE_W-1:0]    r_s2_rx, r_s2_ry, r_s2_cx, r_s2_cy;
    logic [FRAC_BITS-1:0] r_s2_fx, r_s2_fy, r_s3_fx, r_s3_fy, r_s4_fx, r_s4_fy;
    logic [FRAC_BITS-1:0] r_s5_fy, r_s6_fy;

    assign rx = sat_index(r_s1_sx[PROD_W-1:FRAC_BITS], w_last);
    assign ry = sat_index(r_s1_sy[PROD_W-1:FRAC_BITS], h_last);

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_s2_func <= r_s1_func;
            r_s2_gidx <= r_s1_gidx;
            r_s2_gval <= r_s1_gval;
            r_s2_ox   <= r_s1_ox;
            r_s2_oy   <= r_s1_oy;
            r_s2_rx   <= rx;
            r_s2_ry   <= ry;
            // right / bottom neighbor stops at the edge
            r_s2_cx   <= (rx == w_last) ? rx : rx + SIDE_W'(1);
            r_s2_cy   <= (ry == h_last) ? ry : ry + SIDE_W'(1);
            r_s2_fx   <= r_s1_sx[FRAC_BITS-1:0];
            r_s2_fy   <= r_s1_sy[FRAC_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // stage 3: store addresses
    // ------------------------------------------------------------------
    logic [NUM_TAPS-1:0][STORE_AW-1:0] r_s3_addr;

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_s3_func        <= r_s2_func;
            r_s3_gidx        <= r_s2_gidx;
            r_s3_gval        <= r_s2_gval;
            r_s3_ox          <= r_s2_ox;
            r_s3_oy          <= r_s2_oy;
            r_s3_fx          <= r_s2_fx;
            r_s3_fy          <= r_s2_fy;
            r_s3_addr[TAP_A] <= addr_of(r_s2_ry, r_s2_rx, w_lim);
            r_s3_addr[TAP_B] <= addr_of(r_s2_ry, r_s2_cx, w_lim);
            r_s3_addr[TAP_C] <= addr_of(r_s2_cy, r_s2_rx, w_lim);
            r_s3_addr[TAP_D] <= addr_of(r_s2_cy, r_s2_cx, w_lim);
        end
    end

    // ------------------------------------------------------------------
    // stage 4: grid access; writes and reads happen in item order here
    // ------------------------------------------------------------------
    t_grid_wr grid_wr;
    t_grid_rd grid_rd;
    logic [NUM_TAPS-1:0][SAMPLE_W-1:0] tap_q;

    assign grid_wr.en   = rdy4 && r_s3_valid && (r_s3_func == FUNC_LOAD);
    assign grid_wr.addr = r_s3_gidx;
    assign grid_wr.data = r_s3_gval;
    assign grid_rd.en   = rdy4;
    assign grid_rd.addr = r_s3_addr;

    bgu_grid_ram u_grid_ram (
        .i_clk     (i_clk),
        .i_wr      (grid_wr),
        .i_rd      (grid_rd),
        .o_rd_data (tap_q)
    );

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_s4_ox <= r_s3_ox;
            r_s4_oy <= r_s3_oy;
            r_s4_fx <= r_s3_fx;
            r_s4_fy <= r_s3_fy;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: horizontal products, (b-a)*fx and (d-c)*fx
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W:0]    diff_ab, diff_cd;
    logic signed [FRAC_BITS:0]   fx_s;
    logic signed [HP_W-1:0]      r_s5_pt, r_s5_pb;
    logic [SAMPLE_W-1:0]         r_s5_a, r_s5_c;

    assign diff_ab = $signed({1'b0, tap_q[TAP_B]}) - $signed({1'b0, tap_q[TAP_A]});
    assign diff_cd = $signed({1'b0, tap_q[TAP_D]}) - $signed({1'b0, tap_q[TAP_C]});
    assign fx_s    = $signed({1'b0, r_s4_fx});

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r_s5_ox <= r_s4_ox;
            r_s5_oy <= r_s4_oy;
            r_s5_fy <= r_s4_fy;
            r_s5_a  <= tap_q[TAP_A];
            r_s5_c  <= tap_q[TAP_C];
            r_s5_pt <= HP_W'(diff_ab) * HP_W'(fx_s);
            r_s5_pb <= HP_W'(diff_cd) * HP_W'(fx_s);
        end
    end

    // ------------------------------------------------------------------
    // stage 6: row blends, a*ONE + (b-a)*fx
    // ------------------------------------------------------------------
    logic signed [HS_W-1:0] top_sum, bot_sum;
    logic [TOP_W-1:0]       r_s6_top, r_s6_bot;

    assign top_sum = $signed(HS_W'({r_s5_a, FRAC_BITS'(0)})) + HS_W'(r_s5_pt);
    assign bot_sum = $signed(HS_W'({r_s5_c, FRAC_BITS'(0)})) + HS_W'(r_s5_pb);

    always_ff @(posedge i_clk) begin
        if (rdy6) begin
            r_s6_ox  <= r_s5_ox;
            r_s6_oy  <= r_s5_oy;
            r_s6_fy  <= r_s5_fy;
            r_s6_top <= top_sum[TOP_W-1:0];
            r_s6_bot <= bot_sum[TOP_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // stage 7: vertical product, (bot-top)*fy
    // ------------------------------------------------------------------
    logic signed [TOP_W:0]     diff_v;
    logic signed [FRAC_BITS:0] fy_s;
    logic signed [VP_W-1:0]    r_s7_pv;
    logic [TOP_W-1:0]          r_s7_top;

    assign diff_v = $signed({1'b0, r_s6_bot}) - $signed({1'b0, r_s6_top});
    assign fy_s   = $signed({1'b0, r_s6_fy});

    always_ff @(posedge i_clk) begin
        if (rdy7) begin
            r_s7_ox  <= r_s6_ox;
            r_s7_oy  <= r_s6_oy;
            r_s7_top <= r_s6_top;
            r_s7_pv  <= VP_W'(diff_v) * VP_W'(fy_s);
        end
    end

    // ------------------------------------------------------------------
    // stage 8: final blend and truncation (output register)
    // ------------------------------------------------------------------
    logic signed [VS_W-1:0] acc;
    logic [SAMPLE_W-1:0]    r_s8_pixel;
    logic [COORD_BITS-1:0]  r_s8_ox, r_s8_oy;

    assign acc = $signed(VS_W'({r_s7_top, FRAC_BITS'(0)})) + VS_W'(r_s7_pv);

    always_ff @(posedge i_clk) begin
        if (rdy8) begin
            r_s8_ox    <= r_s7_ox;
            r_s8_oy    <= r_s7_oy;
            r_s8_pixel <= acc[2*FRAC_BITS +: SAMPLE_W];
        end
    end

    assign o_out_valid = r_s8_valid;
    assign o_pixel     = r_s8_pixel;
    assign o_pixel_x   = r_s8_ox;
    assign o_pixel_y   = r_s8_oy;

endmodule

### sv/bgu_grid_ram.sv
module bgu_grid_ram (
    input  logic                                                 i_clk,
    input  bgu_pkg::t_grid_wr                                    i_wr,
    input  bgu_pkg::t_grid_rd                                    i_rd,
    output logic [bgu_pkg::NUM_TAPS-1:0][bgu_pkg::SAMPLE_W-1:0]  o_rd_data
);
    import bgu_pkg::*;

    // one copy of the grid per tap: common write, private read port
    for (genvar t = 0; t < NUM_TAPS; t++) begin : g_copy
        logic [SAMPLE_W-1:0] r_mem [STORE_DEPTH];
        logic [SAMPLE_W-1:0] r_q;

        always_ff @(posedge i_clk) begin
            if (i_wr.en) begin
                r_mem[i_wr.addr] <= i_wr.data;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_rd.en) begin
                r_q <= r_mem[i_rd.addr[t]];
            end
        end

        assign o_rd_data[t] = r_q;
    end

endmodule
